### design/sparse_stencil_weight_table_assert.svh
// Assertion macros shared by the stencil table RTL.
`ifndef SPARSE_STENCIL_WEIGHT_TABLE_ASSERT_SVH
`define SPARSE_STENCIL_WEIGHT_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SSWT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stencil table check failed");

// Next-cycle implication, held off during reset.
`define SSWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stencil table check failed");

`endif

### design/sswt_pkg.sv
// Types and constants for the sparse stencil weight table.
package sswt_pkg;

  localparam int WEIGHT_WIDTH = 32;
  localparam int FRAC_BITS    = WEIGHT_WIDTH - 8;
  localparam int NCOMP        = 6;
  localparam int RES_LIMIT    = 32;
  localparam int ADDR_WIDTH   = 4;
  localparam int DATA_WIDTH   = 32;

  typedef enum logic [1:0] {
    REG_COARSE  = 2'd0,
    REG_COMPACT = 2'd1,
    REG_KIND    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_SCALAR = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_SECOND = 2'd2
  } weight_kind_t;

  typedef struct packed {
    logic        [9:0]              source_vertex;
    logic        [9:0]              dest_vertex;
    logic signed [WEIGHT_WIDTH-1:0] element_weight;
    logic signed [WEIGHT_WIDTH-1:0] weight_point;
    logic signed [WEIGHT_WIDTH-1:0] weight_du;
    logic signed [WEIGHT_WIDTH-1:0] weight_dv;
    logic signed [WEIGHT_WIDTH-1:0] weight_duu;
    logic signed [WEIGHT_WIDTH-1:0] weight_duv;
    logic signed [WEIGHT_WIDTH-1:0] weight_dvv;
  } in_item_t;

  typedef struct packed {
    logic        [11:0]             entry_index;
    logic        [9:0]              entry_source;
    logic signed [WEIGHT_WIDTH-1:0] sum_point;
    logic signed [WEIGHT_WIDTH-1:0] sum_du;
    logic signed [WEIGHT_WIDTH-1:0] sum_dv;
    logic signed [WEIGHT_WIDTH-1:0] sum_duu;
    logic signed [WEIGHT_WIDTH-1:0] sum_duv;
    logic signed [WEIGHT_WIDTH-1:0] sum_dvv;
    logic                           was_appended;
    logic                           was_skipped;
    logic                           overflowed;
    logic                           last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RES_RD,
    ST_RES_WAIT,
    ST_WALK,
    ST_ENT_WAIT,
    ST_CONTRIB,
    ST_MERGE,
    ST_SRCH_CMP,
    ST_UPDATE,
    ST_APPEND,
    ST_SKIP
  } state_t;

endpackage

### design/sparse_stencil_weight_table.sv
// Sparse stencil weight table: sequencer, entry and stencil memories, config port.
//
// Input channel item/item_valid/item_stall carries one source stencil element;
// a beat is taken when item_valid is high and item_stall low. Each item gives
// one or more result beats on result/result_valid/result_stall, the last one
// marked by last_result. Registers are written over the APB port (0 coarse
// vertex count, 4 compaction enable, 8 weight kind); the user must write them
// only while idle, and the block itself does not enforce it. Items are handled
// one at a time. A zero-weight item goes straight to a skip beat. Otherwise the
// weights are scaled through the one shared multiplier; a coarse source then
// does one merge, a finer source reads its stencil and per stored entry reads
// it, multiplies it and does one merge. A merge with compaction scans the
// current stencil one entry a cycle (up to MAX_STENCIL) and then writes back
// or appends. A result beat waits in the output register while result_stall is
// high, and the sequencer waits only when it has a new beat ready.
// Reset restores counters, state and config registers; memories are not cleared,
// a stencil is defined once built. MAX_VERTICES is taken to be a power of two.
module sparse_stencil_weight_table
  import sswt_pkg::*;
#(
  parameter int MAX_ENTRIES  = 4096,
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_STENCIL  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  localparam int EAW  = $clog2(MAX_ENTRIES);
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int SZW  = $clog2(MAX_STENCIL + 1);
  localparam int LCAP = (MAX_STENCIL < RES_LIMIT) ? MAX_STENCIL : RES_LIMIT;
  localparam int W    = WEIGHT_WIDTH;
  localparam logic [9:0] VMASK = (MAX_VERTICES >= 1024) ? 10'h3FF : 10'(MAX_VERTICES - 1);

  typedef struct packed {
    logic [9:0]            src;
    logic [NCOMP-1:0][W-1:0] w;
  } entry_t;

  typedef struct packed {
    logic [EAW-1:0] offset;
    logic [SZW-1:0] size;
  } stencil_t;

  // config
  logic [10:0] coarse_vertex_count;
  logic        compact_enable;
  logic [1:0]  weight_kind;

  // control
  state_t state, state_next;
  logic [EAW:0]   entry_count;
  logic [EAW-1:0] cur_start;
  logic [9:0]     cur_dest;
  logic           nonempty;
  logic [SZW-1:0] cur_size;

  // item context
  logic [9:0]     src_red, dst_red, skip_src, m_src;
  logic [W-1:0]   elem_w;
  logic [NCOMP-1:0][W-1:0] in_w, scaled, contrib;
  logic           direct;
  logic [5:0]     walk_j, walk_len;
  logic [EAW-1:0] walk_start, sidx;
  logic [2:0]     mul_cnt;
  logic signed [2*W-1:0] prod_q;

  // memories
  entry_t   entry_mem [MAX_ENTRIES];
  stencil_t sten_mem  [MAX_VERTICES];
  entry_t   entry_q;
  stencil_t sten_q;

  logic           ent_rd, ent_wr, sten_rd, sten_wr;
  logic [EAW-1:0] ent_rd_addr, ent_wr_addr;
  entry_t         ent_wr_data;
  stencil_t       sten_wr_data;

  logic accept, out_free, emit, cfg_wr;
  out_item_t emit_data;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_vertex_count <= '0;
      compact_enable      <= 1'b1;
      weight_kind         <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COARSE:  coarse_vertex_count <= pwdata[10:0];
        REG_COMPACT: compact_enable      <= pwdata[0];
        REG_KIND:    weight_kind         <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COARSE:  prdata = DATA_WIDTH'(coarse_vertex_count);
      REG_COMPACT: prdata = DATA_WIDTH'(compact_enable);
      REG_KIND:    prdata = DATA_WIDTH'(weight_kind);
      default:     prdata = '0;
    endcase
  end

  // ---------------- helpers ----------------
  logic [NCOMP-1:0] comp_on;
  always_comb begin
    case (weight_kind)
      KIND_SCALAR: comp_on = 6'b000001;
      KIND_FIRST:  comp_on = 6'b000111;
      default:     comp_on = 6'b111111;
    endcase
  end

  logic [NCOMP-1:0][W-1:0] item_w;
  assign item_w = {item.weight_dvv, item.weight_duv, item.weight_duu,
                   item.weight_dv, item.weight_du, item.weight_point};

  logic item_zero;
  always_comb begin
    item_zero = (item.element_weight == '0);
    if ((item_w & {{W{comp_on[5]}}, {W{comp_on[4]}}, {W{comp_on[3]}},
                   {W{comp_on[2]}}, {W{comp_on[1]}}, {W{comp_on[0]}}}) == '0)
      item_zero = 1'b1;
  end

  // shared multiplier operands
  logic [W-1:0] mul_a, mul_b;
  logic [2:0]   mul_k;
  assign mul_k = (mul_cnt < 3'd6) ? mul_cnt : 3'd0;
  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = comp_on[mul_k] ? in_w[mul_k] : '0;
      mul_b = elem_w;
    end else begin
      mul_a = entry_q.w[mul_k];
      mul_b = scaled[mul_k];
    end
  end

  logic [2*W-1:0] rnd;
  logic [W-1:0]   mul_res;
  assign rnd     = prod_q + (2*W)'(64'd1 << (FRAC_BITS - 1));
  assign mul_res = rnd[FRAC_BITS+W-1:FRAC_BITS];

  logic [EAW:0] walk_i;
  logic         walk_end, is_last, srch_go, open_new, tbl_full, sten_full;
  logic [SZW-1:0] size_now;
  logic [NCOMP-1:0][W-1:0] sums;

  assign walk_i   = (EAW+1)'(walk_start) + (EAW+1)'(walk_j);
  assign walk_end = (walk_j >= walk_len) || (walk_i >= (EAW+1)'(MAX_ENTRIES));
  assign is_last  = direct || ((walk_j + 6'd1) >= walk_len) ||
                    ((walk_i + 1'b1) >= (EAW+1)'(MAX_ENTRIES));
  assign srch_go  = compact_enable && nonempty && (cur_dest == dst_red) &&
                    ((EAW+1)'(cur_start) < entry_count);
  assign open_new  = !nonempty || (dst_red != cur_dest);
  assign size_now  = open_new ? '0 : cur_size;
  assign tbl_full  = entry_count >= (EAW+1)'(MAX_ENTRIES);
  assign sten_full = size_now >= SZW'(MAX_STENCIL);

  always_comb begin
    for (int c = 0; c < NCOMP; c++) sums[c] = entry_q.w[c] + contrib[c];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    item_stall  = (state != ST_IDLE);
    ent_rd      = 1'b0;
    ent_rd_addr = '0;
    ent_wr      = 1'b0;
    ent_wr_addr = sidx;
    ent_wr_data = '0;
    sten_rd     = 1'b0;
    sten_wr     = 1'b0;
    sten_wr_data = '0;
    emit        = 1'b0;
    emit_data   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = item_zero ? ST_SKIP : ST_SCALE;
      end
      ST_SCALE: begin
        if (mul_cnt == 3'd6)
          state_next = ({1'b0, src_red} < coarse_vertex_count) ? ST_MERGE : ST_RES_RD;
      end
      ST_RES_RD: begin
        sten_rd    = 1'b1;
        state_next = ST_RES_WAIT;
      end
      ST_RES_WAIT: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_SKIP;
        end else begin
          ent_rd      = 1'b1;
          ent_rd_addr = walk_i[EAW-1:0];
          state_next  = ST_ENT_WAIT;
        end
      end
      ST_ENT_WAIT: state_next = ST_CONTRIB;
      ST_CONTRIB: begin
        if (mul_cnt == 3'd6) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (srch_go) begin
          ent_rd      = 1'b1;
          ent_rd_addr = cur_start;
          state_next  = ST_SRCH_CMP;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_SRCH_CMP: begin
        if (entry_q.src == m_src) begin
          state_next = ST_UPDATE;
        end else if ((EAW+1)'(sidx) + 1'b1 < entry_count) begin
          ent_rd      = 1'b1;
          ent_rd_addr = sidx + 1'b1;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          ent_wr      = 1'b1;
          ent_wr_addr = sidx;
          ent_wr_data = '{src: entry_q.src, w: sums};
          emit        = 1'b1;
          emit_data   = '{entry_index: 12'(sidx), entry_source: entry_q.src,
                          sum_point: sums[0], sum_du: sums[1], sum_dv: sums[2],
                          sum_duu: sums[3], sum_duv: sums[4], sum_dvv: sums[5],
                          was_appended: 1'b0, was_skipped: 1'b0, overflowed: 1'b0,
                          last_result: is_last};
          state_next  = is_last ? ST_IDLE : ST_WALK;
        end
      end
      ST_APPEND: begin
        if (out_free) begin
          emit = 1'b1;
          emit_data.entry_source = m_src;
          emit_data.last_result  = is_last;
          if (tbl_full || sten_full) begin
            emit_data.overflowed = 1'b1;
          end else begin
            ent_wr       = 1'b1;
            ent_wr_addr  = entry_count[EAW-1:0];
            ent_wr_data  = '{src: m_src, w: contrib};
            sten_wr      = 1'b1;
            sten_wr_data = '{offset: open_new ? entry_count[EAW-1:0] : cur_start,
                             size: size_now + 1'b1};
            emit_data = '{entry_index: 12'(entry_count[EAW-1:0]), entry_source: m_src,
                          sum_point: contrib[0], sum_du: contrib[1], sum_dv: contrib[2],
                          sum_duu: contrib[3], sum_duv: contrib[4], sum_dvv: contrib[5],
                          was_appended: 1'b1, was_skipped: 1'b0, overflowed: 1'b0,
                          last_result: is_last};
          end
          state_next = is_last ? ST_IDLE : ST_WALK;
        end
      end
      ST_SKIP: begin
        if (out_free) begin
          emit = 1'b1;
          emit_data.entry_source = skip_src;
          emit_data.was_skipped  = 1'b1;
          emit_data.last_result  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- table bookkeeping ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cur_start   <= '0;
      cur_dest    <= '0;
      nonempty    <= 1'b0;
      cur_size    <= '0;
    end else if (sten_wr) begin
      if (open_new) begin
        cur_start <= entry_count[EAW-1:0];
        cur_dest  <= dst_red;
      end
      entry_count <= entry_count + 1'b1;
      cur_size    <= size_now + 1'b1;
      nonempty    <= 1'b1;
    end
  end

  // ---------------- item datapath ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      src_red  <= item.source_vertex & VMASK;
      dst_red  <= item.dest_vertex & VMASK;
      m_src    <= item.source_vertex & VMASK;
      skip_src <= item.source_vertex;
      elem_w   <= item.element_weight;
      in_w     <= item_w;
      direct   <= 1'b1;
      walk_j   <= '0;
      walk_len <= '0;
    end
    if (state == ST_IDLE || state == ST_ENT_WAIT) mul_cnt <= '0;
    else if ((state == ST_SCALE || state == ST_CONTRIB) && mul_cnt != 3'd6)
      mul_cnt <= mul_cnt + 3'd1;
    if (state == ST_SCALE || state == ST_CONTRIB) begin
      prod_q <= $signed(mul_a) * $signed(mul_b);
      if (mul_cnt != 3'd0) begin
        contrib[mul_cnt - 3'd1] <= mul_res;
        if (state == ST_SCALE) scaled[mul_cnt - 3'd1] <= mul_res;
      end
    end
    if (state == ST_CONTRIB && mul_cnt == 3'd6) m_src <= entry_q.src & VMASK;
    if (state == ST_RES_RD) begin
      direct   <= 1'b0;
      skip_src <= src_red;
    end
    if (state == ST_RES_WAIT) begin
      walk_start <= sten_q.offset;
      walk_len   <= (sten_q.size > SZW'(LCAP)) ? 6'(LCAP) : 6'(sten_q.size);
    end
    if ((state == ST_UPDATE || state == ST_APPEND) && emit) walk_j <= walk_j + 6'd1;
    if (state == ST_MERGE) sidx <= cur_start;
    else if (state == ST_SRCH_CMP && ent_rd) sidx <= sidx + 1'b1;
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (ent_wr) entry_mem[ent_wr_addr] <= ent_wr_data;
    if (ent_rd) entry_q <= entry_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sten_wr) sten_mem[VAW'(dst_red)] <= sten_wr_data;
    if (sten_rd) sten_q <= sten_mem[VAW'(src_red)];
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (emit) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) result <= emit_data;
  end

  // ---------------- assertions ----------------
`include "sparse_stencil_weight_table_assert.svh"

  `SSWT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, entry_count <= (EAW+1)'(MAX_ENTRIES))
  `SSWT_ASSERT_NOW(a_size_bound, clk, rst, nonempty, cur_size <= SZW'(MAX_STENCIL))
  `SSWT_ASSERT_NOW(a_skip_clean, clk, rst, result_valid && result.was_skipped,
                   !result.was_appended && !result.overflowed && result.last_result)
  `SSWT_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, item_stall)

endmodule

### tb/sv/sparse_stencil_weight_table_tb.sv
// Self-checking testbench for the sparse stencil weight table.
module sparse_stencil_weight_table_tb;
  import sswt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENTRIES  = 4096;
  localparam int N_VERTICES = 1024;
  localparam int N_STENCIL  = 32;
  localparam logic [31:0] ONE = 32'h0100_0000;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_item_t item;
  logic result_valid;
  logic result_stall;
  out_item_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;

  sparse_stencil_weight_table dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // table image kept by the predictor
  logic [9:0]  tbl_src [N_ENTRIES];
  logic [31:0] tbl_w   [N_ENTRIES][6];
  logic [11:0] stn_offset [N_VERTICES];
  int          stn_size   [N_VERTICES];
  bit          stn_open   [N_VERTICES];
  int          open_list[$];
  int          entry_count;
  int          cur_start;
  int          cur_dest;
  bit          tbl_nonempty;
  int          cfg_coarse;
  bit          cfg_compact;
  int          cfg_kind;

  in_item_t  pending_items[$];
  out_item_t expected_entries[$];
  int idle_pct;
  int stall_pct;
  int errors;
  int cycles;
  int last_dst;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    p = p + 64'sd8388608;
    return p[55:24];
  endfunction

  function automatic out_item_t plain_entry(logic [9:0] src, bit skipped, bit ovf);
    out_item_t r;
    r = '0;
    r.entry_source = src;
    r.was_skipped = skipped;
    r.overflowed = ovf;
    return r;
  endfunction

  function automatic out_item_t stored_entry(int idx, bit appended);
    out_item_t r;
    r = '0;
    r.entry_index = idx[11:0];
    r.entry_source = tbl_src[idx];
    r.sum_point = tbl_w[idx][0];
    r.sum_du = tbl_w[idx][1];
    r.sum_dv = tbl_w[idx][2];
    r.sum_duu = tbl_w[idx][3];
    r.sum_duv = tbl_w[idx][4];
    r.sum_dvv = tbl_w[idx][5];
    r.was_appended = appended;
    return r;
  endfunction

  function automatic out_item_t merge_entry(logic [9:0] src, int dst, logic [31:0] contrib[6]);
    if (cfg_compact && tbl_nonempty && cur_dest == dst) begin
      for (int i = cur_start; i < entry_count; i++) begin
        if (tbl_src[i] == src) begin
          for (int c = 0; c < 6; c++) tbl_w[i][c] = tbl_w[i][c] + contrib[c];
          return stored_entry(i, 0);
        end
      end
    end
    if (entry_count >= N_ENTRIES) return plain_entry(src, 0, 1);
    if (!tbl_nonempty || dst != cur_dest) begin
      stn_offset[dst] = entry_count[11:0];
      stn_size[dst] = 0;
      cur_start = entry_count;
      cur_dest = dst;
      if (!stn_open[dst]) begin
        stn_open[dst] = 1;
        open_list = {open_list, dst};
      end
    end
    if (stn_size[dst] >= N_STENCIL) return plain_entry(src, 0, 1);
    tbl_src[entry_count] = src;
    for (int c = 0; c < 6; c++) tbl_w[entry_count][c] = contrib[c];
    entry_count++;
    stn_size[dst]++;
    tbl_nonempty = 1;
    return stored_entry(entry_count - 1, 1);
  endfunction

  // predict the results of one item and queue it for the driver
  task automatic send_item(in_item_t it);
    logic [31:0] raw[6];
    logic [31:0] scaled[6];
    logic [31:0] contrib[6];
    out_item_t outs[$];
    int ncomp;
    int start;
    int len;
    bit allzero;
    raw = '{it.weight_point, it.weight_du, it.weight_dv,
            it.weight_duu, it.weight_duv, it.weight_dvv};
    ncomp = (cfg_kind == 0) ? 1 : ((cfg_kind == 1) ? 3 : 6);
    allzero = 1;
    for (int c = 0; c < 6; c++) begin
      if (c >= ncomp) raw[c] = '0;
      if (raw[c] != 0) allzero = 0;
      scaled[c] = fx_mul(raw[c], it.element_weight);
    end
    if (it.element_weight == 0 || allzero) begin
      outs = {outs, plain_entry(it.source_vertex, 1, 0)};
    end else if (it.source_vertex < cfg_coarse) begin
      outs = {outs, merge_entry(it.source_vertex, it.dest_vertex, scaled)};
    end else begin
      start = stn_offset[it.source_vertex];
      len = stn_size[it.source_vertex];
      if (len > N_STENCIL) len = N_STENCIL;
      for (int j = 0; j < len; j++) begin
        if (start + j >= N_ENTRIES) break;
        for (int c = 0; c < 6; c++) contrib[c] = fx_mul(tbl_w[start + j][c], scaled[c]);
        outs = {outs, merge_entry(tbl_src[start + j], it.dest_vertex, contrib)};
      end
      if (outs.size() == 0) outs = {outs, plain_entry(it.source_vertex, 1, 0)};
    end
    outs[outs.size() - 1].last_result = 1;
    foreach (outs[k]) expected_entries = {expected_entries, outs[k]};
    pending_items = {pending_items, it};
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_entries.size() != 0 || item_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    logic [31:0] want;
    wait_drained();
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_WIDTH'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    case (idx)
      REG_COARSE:  cfg_coarse = value[10:0];
      REG_COMPACT: cfg_compact = value[0];
      default:     cfg_kind = value[1:0];
    endcase
    case (idx)
      REG_COARSE:  want = {21'd0, value[10:0]};
      REG_COMPACT: want = {31'd0, value[0]};
      default:     want = {30'd0, value[1:0]};
    endcase
    @(posedge clk);
    if (prdata !== want) report("register readback", prdata, want);
  endtask

  task automatic set_mode(int coarse, bit compact, int kind, int idle, int stall);
    write_reg(REG_COARSE, coarse);
    write_reg(REG_COMPACT, 32'(compact));
    write_reg(REG_KIND, kind);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom % 8)
      0: return '0;
      1: return $urandom;
      2: return ($urandom % 2) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic in_item_t make_direct(int src, int dst, logic [31:0] ew, logic [31:0] w);
    in_item_t it;
    it.source_vertex = 10'(src);
    it.dest_vertex = 10'(dst);
    it.element_weight = ew;
    it.weight_point = w;
    it.weight_du = ~w;
    it.weight_dv = w >>> 1;
    it.weight_duu = -w;
    it.weight_duv = w ^ 32'h00ff_00ff;
    it.weight_dvv = w + 1;
    return it;
  endfunction

  task automatic run_random(int count, bit same_dst);
    in_item_t it;
    int fine[$];
    for (int n = 0; n < count; n++) begin
      it.element_weight = ($urandom % 3 == 0) ? ONE : rand_weight();
      it.weight_point = rand_weight();
      it.weight_du = rand_weight();
      it.weight_dv = rand_weight();
      it.weight_duu = rand_weight();
      it.weight_duv = rand_weight();
      it.weight_dvv = rand_weight();
      if (!same_dst && $urandom % 100 < 30) last_dst = $urandom % N_VERTICES;
      it.dest_vertex = 10'(last_dst);
      fine = open_list.find(v) with (v >= cfg_coarse);
      if (fine.size() != 0 && ($urandom % 100 < 30 || cfg_coarse == 0)) begin
        it.source_vertex = 10'(fine[$urandom % fine.size()]);
      end else if (cfg_coarse > 0) begin
        it.source_vertex = 10'($urandom % cfg_coarse);
      end else begin
        // nothing resolvable: only a skipped beat is safe
        it.source_vertex = 10'($urandom);
        it.element_weight = '0;
      end
      send_item(it);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 0;
    end else if (!item_valid || !item_stall) begin
      if (pending_items.size() != 0 && $urandom % 100 >= idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1;
      end else begin
        item_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    result_stall <= ($urandom % 100 < stall_pct);
    if (!rst && pready !== 1'b1) report("pready", {31'd0, pready}, 32'd1);
    if (!rst && result_valid && !result_stall) begin
      if (expected_entries.size() == 0) begin
        report("unexpected beat", result.entry_index, 0);
      end else begin
        want = expected_entries.pop_front();
        if (result.entry_index !== want.entry_index)
          report("entry_index", result.entry_index, want.entry_index);
        if (result.entry_source !== want.entry_source)
          report("entry_source", result.entry_source, want.entry_source);
        if (result.sum_point !== want.sum_point) report("sum_point", result.sum_point, want.sum_point);
        if (result.sum_du !== want.sum_du) report("sum_du", result.sum_du, want.sum_du);
        if (result.sum_dv !== want.sum_dv) report("sum_dv", result.sum_dv, want.sum_dv);
        if (result.sum_duu !== want.sum_duu) report("sum_duu", result.sum_duu, want.sum_duu);
        if (result.sum_duv !== want.sum_duv) report("sum_duv", result.sum_duv, want.sum_duv);
        if (result.sum_dvv !== want.sum_dvv) report("sum_dvv", result.sum_dvv, want.sum_dvv);
        if (result.was_appended !== want.was_appended)
          report("was_appended", result.was_appended, want.was_appended);
        if (result.was_skipped !== want.was_skipped)
          report("was_skipped", result.was_skipped, want.was_skipped);
        if (result.overflowed !== want.overflowed)
          report("overflowed", result.overflowed, want.overflowed);
        if (result.last_result !== want.last_result)
          report("last_result", result.last_result, want.last_result);
      end
    end
  end

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    last_dst = 10;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    entry_count = 0;
    cur_start = 0;
    cur_dest = 0;
    tbl_nonempty = 0;
    cfg_coarse = 0;
    cfg_compact = 1;
    cfg_kind = 0;
    foreach (stn_open[v]) stn_open[v] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: appends, merges, extremes, skips, new stencils
    set_mode(1024, 1, KIND_SECOND, 0, 0);
    send_item(make_direct(5, 10, ONE, 32'h0180_0000));
    send_item(make_direct(5, 10, ONE, 32'hff40_0000));
    send_item(make_direct(0, 10, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_direct(1023, 10, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_direct(0, 10, 32'h8000_0000, 32'h8000_0000));
    send_item(make_direct(7, 10, '0, 32'h0100_0000));
    send_item(make_direct(7, 10, ONE, '0));
    send_item(make_direct(5, 1023, ONE, 32'h0080_0000));
    send_item(make_direct(5, 10, ONE, 32'h0040_0000));
    send_item(make_direct(0, 0, 32'hffff_ffff, 32'hffff_ffff));
    send_item(make_direct(1023, 1023, 32'h0000_0001, 32'h0000_0001));
    // fine sources resolve their stored stencils
    set_mode(16, 1, KIND_FIRST, 0, 0);
    send_item(make_direct(1023, 20, ONE, 32'h0100_0000));
    send_item(make_direct(10, 20, 32'h0200_0000, 32'hfe00_0000));
    send_item(make_direct(10, 20, ONE, 32'h0100_0000));
    send_item(make_direct(800, 20, '0, 32'h0100_0000));
    send_item(make_direct(3, 20, ONE, 32'h0300_0000));
    set_mode(16, 0, 3, 0, 0);
    send_item(make_direct(20, 21, ONE, 32'h0100_0000));
    send_item(make_direct(20, 21, ONE, 32'h0100_0000));

    set_mode(1024, 1, KIND_FIRST, 0, 0);
    run_random(40, 0);
    set_mode(512, 1, KIND_SECOND, 48, 0);
    run_random(40, 0);
    // no compaction, one destination: runs the stencil past its limit
    set_mode(300, 0, KIND_SCALAR, 0, 48);
    run_random(40, 1);
    set_mode(0, 1, 3, 9, 9);
    run_random(40, 0);
    set_mode(1024, 0, KIND_SECOND, 0, 0);
    run_random(52, 0);

    wait_drained();
    repeat (50) @(posedge clk);
    foreach (expected_entries[k]) report("missing beat", expected_entries[k].entry_index, 0);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
